### hdl/assert_macros.svh
// Assertion macros shared by the heading block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define MHS_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MHS_ASSERT_NR(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mhs_pkg.sv
// Types, constants and helper functions for the compass heading block.
package mhs_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int GUARD_BITS    = 8;
	localparam int TABLE_LEN     = 24;
	localparam int CORDIC_ITERS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

	// vector length grows by sqrt(2) times the CORDIC gain; three bits of headroom
	localparam int XY_W  = SAMPLE_BITS + GUARD_BITS + 3;
	localparam int ANG_W = 25;
	localparam int RAW_W = 17;
	localparam int HDG_W = 18;

	localparam int FULL_TURN     = 36000;
	localparam int SECTOR_WIDTH  = 2250;
	localparam int SECTOR_HALF   = 1125;
	localparam int SECTOR_COUNT  = 16;
	localparam int QUARTER_UNITS = 2304000;
	localparam int ROUND_HALF    = 128;
	localparam int DECL_RESET    = 1142;

	typedef logic signed [XY_W-1:0]  xy_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [RAW_W-1:0] raw_t;
	typedef logic signed [HDG_W-1:0] hdg_t;

	// atan(2^-i) in units of 1/25600 degree
	localparam ang_t ATAN_UNITS [TABLE_LEN] = '{
		ang_t'(1152000), ang_t'(680065), ang_t'(359328), ang_t'(182400),
		ang_t'(91554),   ang_t'(45822),  ang_t'(22916),  ang_t'(11459),
		ang_t'(5730),    ang_t'(2865),   ang_t'(1432),   ang_t'(716),
		ang_t'(358),     ang_t'(179),    ang_t'(90),     ang_t'(45),
		ang_t'(22),      ang_t'(11),     ang_t'(6),      ang_t'(3),
		ang_t'(1),       ang_t'(1),      ang_t'(0),      ang_t'(0)
	};

	typedef struct packed {
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
	} mag_word_t;

	typedef struct packed {
		logic [15:0] heading_centideg;
		logic [3:0]  compass_sector;
	} heading_word_t;

	typedef struct packed {
		logic zero;
		xy_t  x;
		xy_t  y;
		ang_t ang;
	} cordic_word_t;

	// Count the sector boundaries at or below h; the boundary at 348.75 deg wraps to N.
	function automatic logic [3:0] sector_of(logic [15:0] h);
		logic [4:0] cnt;
		cnt = '0;
		for (int k = 1; k <= SECTOR_COUNT; k++) begin
			if ({1'b0, h} >= 17'(k * SECTOR_WIDTH - SECTOR_HALF)) begin
				cnt = cnt + 5'd1;
			end
		end
		return cnt[3:0];
	endfunction

endpackage

### hdl/mhs_prerot.sv
// Input stage: guard scaling, quadrant pre-rotation and zero-vector detect.
module mhs_prerot
	import mhs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         nxt_en,
	input  logic         in_vld,
	input  mag_word_t    in_word,
	output logic         adv,
	output logic         out_vld,
	output cordic_word_t out_word
);

	logic signed [SAMPLE_BITS-1:0] sx;
	logic signed [SAMPLE_BITS-1:0] sy;
	xy_t                           gx;
	xy_t                           gy;
	cordic_word_t                  pre;
	logic                          vld_s1;
	cordic_word_t                  word_s1;

	assign sx = in_word.mag_x[SAMPLE_BITS-1:0];
	assign sy = in_word.mag_y[SAMPLE_BITS-1:0];
	assign gx = xy_t'(sx) <<< GUARD_BITS;
	assign gy = xy_t'(sy) <<< GUARD_BITS;

	// rotate the left half-plane into the right one
	always_comb begin
		pre.zero = (sx == '0) && (sy == '0);
		pre.x    = gx;
		pre.y    = gy;
		pre.ang  = '0;
		if (gx < 0) begin
			if (gy >= 0) begin
				pre.x   = gy;
				pre.y   = -gx;
				pre.ang = ang_t'(QUARTER_UNITS);
			end else begin
				pre.x   = -gy;
				pre.y   = gx;
				pre.ang = -ang_t'(QUARTER_UNITS);
			end
		end
	end

	assign adv = !vld_s1 || nxt_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= pre;
		end
	end

	assign out_vld  = vld_s1;
	assign out_word = word_s1;

endmodule

### hdl/mhs_cordic.sv
// Unrolled vectoring CORDIC, one micro-rotation per pipeline stage.
module mhs_cordic
	import mhs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         nxt_en,
	input  logic         in_vld,
	input  cordic_word_t in_word,
	output logic         adv,
	output logic         out_vld,
	output cordic_word_t out_word
);

	logic         vld_s  [CORDIC_ITERS];
	cordic_word_t word_s [CORDIC_ITERS];
	logic         src_vld [CORDIC_ITERS+1];
	cordic_word_t src     [CORDIC_ITERS+1];
	logic         en      [CORDIC_ITERS+1];

	assign src_vld[0] = in_vld;
	assign src[0]     = in_word;
	assign en[CORDIC_ITERS] = nxt_en;

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		xy_t          dx;
		xy_t          dy;
		cordic_word_t nw;

		assign dx = src[i].y >>> i;
		assign dy = src[i].x >>> i;

		// drive y toward zero; both updates use the old x and y
		always_comb begin
			nw = src[i];
			if (!src[i].y[XY_W-1]) begin
				nw.x   = src[i].x + dx;
				nw.y   = src[i].y - dy;
				nw.ang = src[i].ang + ATAN_UNITS[i];
			end else begin
				nw.x   = src[i].x - dx;
				nw.y   = src[i].y + dy;
				nw.ang = src[i].ang - ATAN_UNITS[i];
			end
		end

		assign en[i] = !vld_s[i] || en[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en[i]) begin
				vld_s[i] <= src_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en[i]) begin
				word_s[i] <= nw;
			end
		end

		assign src_vld[i+1] = vld_s[i];
		assign src[i+1]     = word_s[i];
	end

	assign adv      = en[0];
	assign out_vld  = src_vld[CORDIC_ITERS];
	assign out_word = src[CORDIC_ITERS];

endmodule

### hdl/mhs_wrap.sv
// Rounding, declination add and wrap of the heading into one turn.
module mhs_wrap
	import mhs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               nxt_en,
	input  logic               in_vld,
	input  cordic_word_t       in_word,
	input  logic signed [15:0] decl,
	output logic               adv,
	output logic               out_vld,
	output logic [15:0]        out_hdg
);

	ang_t        rnd;
	ang_t        rsh;
	raw_t        raw;
	hdg_t        sum;
	hdg_t        wrapped;
	logic        en1;
	logic        en2;
	logic        vld_s1;
	hdg_t        sum_s1;
	logic        vld_s2;
	logic [15:0] hdg_s2;

	// round to nearest centidegree, halves up
	always_comb begin
		rnd = in_word.ang + ang_t'(ROUND_HALF);
		rsh = rnd >>> GUARD_BITS;
		raw = in_word.zero ? '0 : rsh[RAW_W-1:0];
		sum = hdg_t'(raw) + hdg_t'(decl);
	end

	always_comb begin
		if (sum_s1 < -hdg_t'(FULL_TURN)) begin
			wrapped = sum_s1 + hdg_t'(2 * FULL_TURN);
		end else if (sum_s1 < 0) begin
			wrapped = sum_s1 + hdg_t'(FULL_TURN);
		end else if (sum_s1 >= hdg_t'(FULL_TURN)) begin
			wrapped = sum_s1 - hdg_t'(FULL_TURN);
		end else begin
			wrapped = sum_s1;
		end
	end

	assign en2 = !vld_s2 || nxt_en;
	assign en1 = !vld_s1 || en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= in_vld;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			sum_s1 <= sum;
		end
		if (en2) begin
			hdg_s2 <= wrapped[15:0];
		end
	end

	assign adv     = en1;
	assign out_vld = vld_s2;
	assign out_hdg = hdg_s2;

endmodule

### hdl/magnetometer_heading_sector_top.sv
// Top level of the compass heading block: register, pipeline chain and output stage.
//
//   Channel   Dir  Handshake                 Word
//   in        in   in_valid / in_stall       mag_word_t: mag_x, mag_y
//   out       out  out_valid / out_stall     heading_word_t: heading_centideg, compass_sector
//   decl      in   decl_we                   signed 16-bit declination, centidegrees
//
// One word enters per cycle while in_stall is low. The stages, in order, are the
// pre-rotation, one stage per CORDIC micro-rotation, round plus declination, wrap, and
// the output register that also looks up the sector.
// Every stage carries its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up under a stall and a new word is taken while a result waits.
// Reset clears all valid bits and loads the declination with 11.42 degrees.
`include "assert_macros.svh"

module magnetometer_heading_sector_top
	import mhs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mag_word_t          in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output heading_word_t      out_word,
	input  logic               decl_we,
	input  logic signed [15:0] decl_wdata
);

	logic signed [15:0] decl_q;

	logic          pre_adv;
	logic          pre_vld;
	cordic_word_t  pre_word;
	logic          cor_adv;
	logic          cor_vld;
	cordic_word_t  cor_word;
	logic          wrp_adv;
	logic          wrp_vld;
	logic [15:0]   wrp_hdg;

	logic          out_en;
	logic          out_valid_s;
	heading_word_t out_word_s;

	// Declination register; the user must write it only while the pipeline is drained (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= 16'(DECL_RESET);
		end else if (decl_we) begin
			decl_q <= decl_wdata;
		end
	end

	mhs_prerot u_prerot (
		.clk      (clk),
		.arst_n   (arst_n),
		.nxt_en   (cor_adv),
		.in_vld   (in_valid),
		.in_word  (in_word),
		.adv      (pre_adv),
		.out_vld  (pre_vld),
		.out_word (pre_word)
	);

	mhs_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.nxt_en   (wrp_adv),
		.in_vld   (pre_vld),
		.in_word  (pre_word),
		.adv      (cor_adv),
		.out_vld  (cor_vld),
		.out_word (cor_word)
	);

	mhs_wrap u_wrap (
		.clk     (clk),
		.arst_n  (arst_n),
		.nxt_en  (out_en),
		.in_vld  (cor_vld),
		.in_word (cor_word),
		.decl    (decl_q),
		.adv     (wrp_adv),
		.out_vld (wrp_vld),
		.out_hdg (wrp_hdg)
	);

	// Output stage: advance when empty or when the sink takes the held word.
	assign out_en = !out_valid_s || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s <= 1'b0;
		end else if (out_en) begin
			out_valid_s <= wrp_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			out_word_s.heading_centideg <= wrp_hdg;
			out_word_s.compass_sector   <= sector_of(wrp_hdg);
		end
	end

	// Hold off the source only when the whole chain is full behind a stalled sink.
	assign in_stall  = !pre_adv;
	assign out_valid = out_valid_s;
	assign out_word  = out_word_s;

	`MHS_ASSERT(a_stall_from_sink, in_stall |-> (out_valid && out_stall), "input stalled without a stalled result")
	`MHS_ASSERT(a_heading_range, out_valid |-> (out_word.heading_centideg < 16'(FULL_TURN)), "heading outside one turn")
	`MHS_ASSERT_NR(a_decl_reset, $rose(arst_n) |-> (decl_q == 16'(DECL_RESET)), "declination not at reset value")

endmodule

### sim/magnetometer_heading_sector_top_tb.sv
// Self-checking testbench for the compass heading block: CORDIC heading, declination, sector.
module magnetometer_heading_sector_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mhs_pkg::mag_word_t;
	import mhs_pkg::heading_word_t;

	// Pipeline depth: 16 micro-rotations plus 4 stages.
	localparam int PIPE_LATENCY = 20;
	// Cycles without any accepted word before the run is declared hung.
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_CHUNKS = 12;
	localparam int CHUNK_WORDS   = 152;
	// Long receiver hold-off: starts once this many results have come back.
	localparam int CROWD_AFTER   = 400;
	localparam int CROWD_CYCLES  = 150;

	// Predictor constants: angles in 1/256 centidegree, samples with 8 guard bits.
	localparam int     ROTATIONS      = 16;
	localparam longint GUARD_GAIN     = 256;
	localparam longint QUARTER_ANG    = 2304000;
	localparam longint HALF_LSB       = 128;
	localparam longint TURN_CD        = 36000;
	localparam longint SECTOR_SPAN_CD = 2250;
	localparam longint SECTOR_HALF_CD = 1125;
	localparam longint ATAN_STEP [24] = '{
		1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
		5730, 2865, 1432, 716, 358, 179, 90, 45,
		22, 11, 6, 3, 1, 1, 0, 0
	};

	localparam logic signed [15:0] RESET_DECL = 16'sd1142;
	localparam logic signed [15:0] EDGE_VALUES [5] = '{
		16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001
	};

	// Declinations for the first DECL_PLAN_LEN random chunks: range ends, sector boundaries, out-of-range words.
	localparam int DECL_PLAN_LEN = 10;
	localparam logic signed [15:0] DECL_PLAN [DECL_PLAN_LEN] = '{
		16'sd0, 16'sd18000, -16'sd18000, 16'sd1125, -16'sd1125,
		16'sh7FFF, 16'sh8000, -16'sd1, 16'sd17999, 16'sd1124
	};

	// Directed words: axes, diagonals, full-scale corners, zero vector, both pre-rotations.
	localparam int DIRECTED_LEN = 20;
	localparam mag_word_t DIRECTED [DIRECTED_LEN] = '{
		'{16'sh0000, 16'sh0000}, '{16'sh7FFF, 16'sh0000}, '{16'sh8000, 16'sh0000},
		'{16'sh0000, 16'sh7FFF}, '{16'sh0000, 16'sh8000}, '{16'sh7FFF, 16'sh7FFF},
		'{16'sh8000, 16'sh8000}, '{16'sh7FFF, 16'sh8000}, '{16'sh8000, 16'sh7FFF},
		'{16'shFFFF, 16'sh0000}, '{16'sh0000, 16'shFFFF}, '{16'sh0001, 16'sh0000},
		'{16'sh0000, 16'sh0001}, '{16'shFFFF, 16'shFFFF}, '{16'shFFFF, 16'sh0001},
		'{16'sh0001, 16'shFFFF}, '{16'sh8000, 16'shFFFF}, '{16'shFFF9, 16'sh0000},
		'{16'sh0064, 16'sh0029}, '{16'shAAAA, 16'sh5555}
	};

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	mag_word_t          in_word    = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	heading_word_t      out_word;
	logic               decl_we    = 1'b0;
	logic signed [15:0] decl_wdata = '0;

	// Samples waiting to be offered; the front one is on the bus while in_valid is high.
	mag_word_t          queued_samples[$];
	// Headings predicted for accepted samples, oldest first.
	heading_word_t      expected_headings[$];
	logic signed [15:0] declination_now = RESET_DECL;

	int src_idle_pct = 21;
	int snk_idle_pct = 64;
	int error_count  = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int crowd_left   = 0;
	bit crowd_done   = 1'b0;

	magnetometer_heading_sector_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.decl_we    (decl_we),
		.decl_wdata (decl_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Vectoring CORDIC on 64-bit integers, then declination, wrap and sector bin.
	function automatic heading_word_t predict_heading(mag_word_t s, logic signed [15:0] decl);
		longint x, y, ang, t, dx, dy, h;
		heading_word_t r;
		x = longint'($signed(s.mag_x));
		y = longint'($signed(s.mag_y));
		ang = 0;
		// zero vector keeps a raw heading of 0
		if (x != 0 || y != 0) begin
			x = x * GUARD_GAIN;
			y = y * GUARD_GAIN;
			// fold the left half-plane into the right one by a quarter turn
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y;
					y = -t;
					ang = QUARTER_ANG;
				end else begin
					x = -y;
					y = t;
					ang = -QUARTER_ANG;
				end
			end
			for (int i = 0; i < ROTATIONS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y >= 0) begin
					x = x + dx;
					y = y - dy;
					ang = ang + ATAN_STEP[i];
				end else begin
					x = x - dx;
					y = y + dy;
					ang = ang - ATAN_STEP[i];
				end
			end
			ang = (ang + HALF_LSB) >>> 8;
		end
		// wrap both below zero and at or above a full turn
		h = (ang + longint'(decl)) % TURN_CD;
		if (h < 0) begin
			h = h + TURN_CD;
		end
		r.heading_centideg = 16'(h);
		r.compass_sector   = 4'(((h + SECTOR_HALF_CD) / SECTOR_SPAN_CD) % 16);
		return r;
	endfunction

	// Mix full-range words with small magnitudes and the axis extremes.
	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: begin
				return 16'($urandom_range(0, 255)) - 16'd128;
			end
			1: begin
				return EDGE_VALUES[$urandom_range(0, 4)];
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Block until every queued sample has been accepted and every result checked.
	task automatic wait_drained();
		while (queued_samples.size() != 0 || expected_headings.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	// Sender: predict on acceptance, hold a stalled word, otherwise offer or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_headings.push_back(predict_heading(in_word, declination_now));
				void'(queued_samples.pop_front());
			end
			if (!in_valid || !in_stall) begin
				if (queued_samples.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					in_valid <= 1'b1;
					in_word  <= queued_samples[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random back-pressure plus one long hold-off that fills the pipeline.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (crowd_left > 0) begin
			crowd_left <= crowd_left - 1;
			out_stall  <= 1'b1;
		end else if (!crowd_done && results_seen >= CROWD_AFTER) begin
			crowd_done <= 1'b1;
			crowd_left <= CROWD_CYCLES;
			out_stall  <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
		end
	end

	// Monitor: compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		heading_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen <= results_seen + 1;
			if (expected_headings.size() == 0) begin
				if (error_count < 10)
					$display("unexpected result word: heading %0d sector %0d",
						out_word.heading_centideg, out_word.compass_sector);
				error_count <= error_count + 1;
			end else begin
				want = expected_headings.pop_front();
				if (out_word.heading_centideg !== want.heading_centideg ||
					out_word.compass_sector !== want.compass_sector) begin
					if (error_count < 10)
						$display("result %0d: expected heading %0d sector %0d, got heading %0d sector %0d",
							results_seen, want.heading_centideg, want.compass_sector,
							out_word.heading_centideg, out_word.compass_sector);
					error_count <= error_count + 1;
				end
			end
		end
	end

	// Watchdog: count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus: directed words at the reset declination, then random chunks, each under
	// its own declination written while the pipeline is empty.
	initial begin
		mag_word_t s;
		logic signed [15:0] decl_next;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		for (int k = 0; k < DIRECTED_LEN; k++)
			queued_samples.push_back(DIRECTED[k]);
		wait_drained();

		for (int c = 0; c < RANDOM_CHUNKS; c++) begin
			// swap idle rates for the middle third, drop idling for the last
			if (c == RANDOM_CHUNKS / 3) begin
				src_idle_pct = 64;
				snk_idle_pct = 21;
			end else if (c == 2 * RANDOM_CHUNKS / 3) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			if (c < DECL_PLAN_LEN)
				decl_next = DECL_PLAN[c];
			else
				decl_next = 16'($urandom_range(0, 36000)) - 16'sd18000;

			// write the register while idle; the model follows on the capturing edge
			@(posedge clk);
			decl_we    <= 1'b1;
			decl_wdata <= decl_next;
			@(posedge clk);
			decl_we    <= 1'b0;
			declination_now = decl_next;

			@(negedge clk);
			repeat (CHUNK_WORDS) begin
				s.mag_x = rand_axis();
				s.mag_y = rand_axis();
				queued_samples.push_back(s);
			end
			wait_drained();
		end

		// let any stray result word surface before the verdict
		repeat (PIPE_LATENCY + 5) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### magnetometer_heading_sector_top.f
+incdir+hdl
hdl/mhs_pkg.sv
hdl/mhs_prerot.sv
hdl/mhs_cordic.sv
hdl/mhs_wrap.sv
hdl/magnetometer_heading_sector_top.sv
sim/magnetometer_heading_sector_top_tb.sv
